// ----- hw/rtl/lmcdr_pkg.sv -----
package lmcdr_pkg;

	localparam int MatrixRowsDefault = 16;
	localparam int MatrixColsDefault = 24;

	localparam int SmallH = 5;
	localparam int SmallW = 3;
	localparam int BigH = 7;
	localparam int BigW = 4;
	localparam int SmallTop = 5;
	localparam int BigTop = 4;
	localparam int ColonRowA = 6;
	localparam int ColonRowB = 8;
	localparam int ColonCol = 12;

	// Configuration register indexes.
	localparam logic [1:0] RegBigFont = 2'd0;
	localparam logic [1:0] RegRowShift = 2'd1;
	localparam logic [1:0] RegColShift = 2'd2;
	localparam logic [1:0] RegColorMode = 2'd3;

	typedef logic [3:0] digit_t;
	typedef logic [4:0] face_pos_t;

	typedef struct packed {
		logic [4:0] pixel_row;
		logic [4:0] pixel_col;
		logic [4:0] hours;
		logic [5:0] minutes;
		logic [23:0] drive_color;
	} pix_in_t;

	typedef struct packed {
		logic pixel_lit;
		logic [23:0] pixel_color;
	} pix_out_t;

	typedef struct packed {
		logic big_font;
		logic [3:0] row_shift;
		logic [4:0] col_shift;
		logic [1:0] color_mode;
	} cfg_t;

	function automatic int small_col(input int d);
		case (d)
			0: return 4;
			1: return 8;
			2: return 14;
			default: return 18;
		endcase
	endfunction

	function automatic int big_col(input int d);
		case (d)
			0: return 2;
			1: return 7;
			2: return 14;
			default: return 19;
		endcase
	endfunction

	// Rows top to bottom from the most significant chunk; leftmost column is the row's MSB.
	function automatic logic [14:0] small_glyph(input digit_t g);
		case (g)
			4'd0: return {3'd7, 3'd5, 3'd5, 3'd5, 3'd7};
			4'd1: return {3'd1, 3'd1, 3'd1, 3'd1, 3'd1};
			4'd2: return {3'd7, 3'd1, 3'd7, 3'd4, 3'd7};
			4'd3: return {3'd7, 3'd1, 3'd7, 3'd1, 3'd7};
			4'd4: return {3'd5, 3'd5, 3'd7, 3'd1, 3'd1};
			4'd5: return {3'd7, 3'd4, 3'd7, 3'd1, 3'd7};
			4'd6: return {3'd7, 3'd4, 3'd7, 3'd5, 3'd7};
			4'd7: return {3'd7, 3'd1, 3'd1, 3'd1, 3'd1};
			4'd8: return {3'd7, 3'd5, 3'd7, 3'd5, 3'd7};
			4'd9: return {3'd7, 3'd5, 3'd7, 3'd1, 3'd7};
			default: return '0;
		endcase
	endfunction

	function automatic logic [27:0] big_glyph(input digit_t g);
		case (g)
			4'd0: return {4'd15, 4'd9, 4'd9, 4'd9, 4'd9, 4'd9, 4'd15};
			4'd1: return {4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2};
			4'd2: return {4'd15, 4'd1, 4'd1, 4'd15, 4'd8, 4'd8, 4'd15};
			4'd3: return {4'd15, 4'd1, 4'd1, 4'd7, 4'd1, 4'd1, 4'd15};
			4'd4: return {4'd9, 4'd9, 4'd9, 4'd15, 4'd1, 4'd1, 4'd1};
			4'd5: return {4'd15, 4'd8, 4'd8, 4'd15, 4'd1, 4'd1, 4'd15};
			4'd6: return {4'd15, 4'd8, 4'd8, 4'd15, 4'd9, 4'd9, 4'd15};
			4'd7: return {4'd15, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1};
			4'd8: return {4'd15, 4'd9, 4'd9, 4'd15, 4'd9, 4'd9, 4'd15};
			4'd9: return {4'd15, 4'd9, 4'd9, 4'd15, 4'd1, 4'd1, 4'd15};
			default: return '0;
		endcase
	endfunction

	// Splits a value below 64 into tens and ones, tens in the upper nibble.
	function automatic logic [7:0] split_decimal(input logic [5:0] v);
		logic [3:0] tens;
		logic [5:0] ones;
		tens = '0;
		ones = v;
		if (v >= 6'd60) begin
			tens = 4'd6;
			ones = v - 6'd60;
		end else if (v >= 6'd50) begin
			tens = 4'd5;
			ones = v - 6'd50;
		end else if (v >= 6'd40) begin
			tens = 4'd4;
			ones = v - 6'd40;
		end else if (v >= 6'd30) begin
			tens = 4'd3;
			ones = v - 6'd30;
		end else if (v >= 6'd20) begin
			tens = 4'd2;
			ones = v - 6'd20;
		end else if (v >= 6'd10) begin
			tens = 4'd1;
			ones = v - 6'd10;
		end
		return {tens, ones[3:0]};
	endfunction

	// True when face cell (lr, lc), before shift and wrap, is lit by a digit or the colon.
	function automatic logic face_hit(input face_pos_t lr, input face_pos_t lc,
			input logic [3:0][3:0] digits, input logic big);
		logic hit;
		int rr;
		int cc;
		int ir;
		int ic;
		logic [14:0] sg;
		logic [27:0] bg;
		rr = int'(lr);
		cc = int'(lc);
		hit = (rr == ColonRowA || rr == ColonRowB) && cc == ColonCol;
		for (int d = 0; d < 4; d++) begin
			sg = small_glyph(digits[d]);
			bg = big_glyph(digits[d]);
			if (big) begin
				ir = rr - BigTop;
				ic = cc - big_col(d);
				if (ir >= 0 && ir < BigH && ic >= 0 && ic < BigW) begin
					if (bg[(BigH - 1 - ir) * BigW + (BigW - 1 - ic)]) begin
						hit = 1'b1;
					end
				end
			end else begin
				ir = rr - SmallTop;
				ic = cc - small_col(d);
				if (ir >= 0 && ir < SmallH && ic >= 0 && ic < SmallW) begin
					if (sg[(SmallH - 1 - ir) * SmallW + (SmallW - 1 - ic)]) begin
						hit = 1'b1;
					end
				end
			end
		end
		return hit;
	endfunction

endpackage

// ----- hw/rtl/lmcdr_pixel_eval.sv -----
module lmcdr_pixel_eval #(
	parameter int MATRIX_ROWS = lmcdr_pkg::MatrixRowsDefault,
	parameter int MATRIX_COLS = lmcdr_pkg::MatrixColsDefault
) (
	input lmcdr_pkg::pix_in_t pix,
	input lmcdr_pkg::cfg_t cfg,
	output logic in_range,
	output lmcdr_pkg::pix_out_t result
);
	import lmcdr_pkg::*;

	localparam int RowW = $clog2(MATRIX_ROWS + 32) + 1;
	localparam int ColW = $clog2(MATRIX_COLS + 32) + 1;
	localparam logic signed [RowW-1:0] RowsS = RowW'(MATRIX_ROWS);
	localparam logic signed [ColW-1:0] ColsS = ColW'(MATRIX_COLS);

	logic [7:0] hour_split;
	logic [7:0] min_split;
	logic [3:0][3:0] digits;
	logic signed [RowW-1:0] row_s;
	logic signed [ColW-1:0] col_s;
	logic signed [RowW-1:0] face_r [2];
	logic signed [ColW-1:0] face_c [2];
	logic [1:0] r_ok;
	logic [1:0] c_ok;
	logic lit;

	assign hour_split = split_decimal({1'b0, pix.hours});
	assign min_split = split_decimal(pix.minutes);
	assign digits = {min_split[3:0], min_split[7:4], hour_split[3:0], hour_split[7:4]};

	assign row_s = RowW'(signed'({1'b0, pix.pixel_row}));
	assign col_s = ColW'(signed'({1'b0, pix.pixel_col}));
	assign in_range = (row_s != '0) && (row_s <= RowsS) && (col_s != '0) && (col_s <= ColsS);

	// A pixel is reached by a shifted cell either directly or after one wrap,
	// so each axis has two candidate face coordinates.
	always_comb begin
		face_r[0] = row_s - RowW'(signed'({1'b0, cfg.row_shift}));
		face_r[1] = row_s + RowsS - RowW'(signed'({1'b0, cfg.row_shift}));
		face_c[0] = col_s - ColW'(signed'({1'b0, cfg.col_shift}));
		face_c[1] = col_s + ColsS - ColW'(signed'({1'b0, cfg.col_shift}));
		for (int i = 0; i < 2; i++) begin
			r_ok[i] = (face_r[i][RowW-1:5] == '0);
			c_ok[i] = (face_c[i][ColW-1:5] == '0);
		end
	end

	always_comb begin
		lit = 1'b0;
		for (int i = 0; i < 2; i++) begin
			for (int j = 0; j < 2; j++) begin
				if (r_ok[i] && c_ok[j] &&
						face_hit(face_r[i][4:0], face_c[j][4:0], digits, cfg.big_font)) begin
					lit = 1'b1;
				end
			end
		end
	end

	always_comb begin
		result.pixel_lit = in_range && lit;
		if (!in_range) begin
			result.pixel_color = '0;
		end else if (cfg.color_mode[1]) begin
			result.pixel_color = lit ? '0 : pix.drive_color;
		end else begin
			result.pixel_color = lit ? pix.drive_color : '0;
		end
	end

endmodule

// ----- hw/rtl/led_matrix_clock_digit_renderer_top.sv -----
// A word accepted with start is held in the input register (pix_s1) and evaluated; its result
// is then held in the result register (res_s2), which drives pixel_out with done high.
// Throughput: one word per clock cycle; busy is always low.
// The receiver cannot stall: each result is shown for exactly one cycle.
// Reset (arst_n low, asynchronous) clears both valid flags and sets the
// configuration to big font, no shift and single color mode.
module led_matrix_clock_digit_renderer_top #(
	parameter int MATRIX_ROWS = lmcdr_pkg::MatrixRowsDefault,
	parameter int MATRIX_COLS = lmcdr_pkg::MatrixColsDefault
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input lmcdr_pkg::pix_in_t pixel_in,
	output logic done,
	output lmcdr_pkg::pix_out_t pixel_out,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [4:0] cfg_data
);
	import lmcdr_pkg::*;

	cfg_t cfg_q;
	pix_in_t pix_s1;
	logic valid_s1;
	logic valid_s2;
	pix_out_t res_s2;
	pix_out_t res_comb;
	logic in_range_s1;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.big_font <= 1'b1;
			cfg_q.row_shift <= '0;
			cfg_q.col_shift <= '0;
			cfg_q.color_mode <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				RegBigFont: cfg_q.big_font <= cfg_data[0];
				RegRowShift: cfg_q.row_shift <= cfg_data[3:0];
				RegColShift: cfg_q.col_shift <= cfg_data[4:0];
				RegColorMode: cfg_q.color_mode <= cfg_data[1:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			pix_s1 <= pixel_in;
		end
		if (valid_s1) begin
			res_s2 <= res_comb;
		end
	end

	lmcdr_pixel_eval #(
		.MATRIX_ROWS(MATRIX_ROWS),
		.MATRIX_COLS(MATRIX_COLS)
	) u_eval (
		.pix(pix_s1),
		.cfg(cfg_q),
		.in_range(in_range_s1),
		.result(res_comb)
	);

	assign done = valid_s2;
	assign pixel_out = res_s2;

	a_done_follows_s1: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(valid_s1))
		else $error("done without a word in the first stage");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> valid_s1)
		else $error("accepted word did not reach the first stage");

	a_outside_dark: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !in_range_s1) |=> (!pixel_out.pixel_lit && pixel_out.pixel_color == '0))
		else $error("pixel outside the matrix was driven");

endmodule
